// ===== hdl/obd_pkg.sv =====
// Shared types and constants for the OBD PID value decoder.
// No dependencies.
`default_nettype none
package obd_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int VALUE_W       = 50;
    localparam int OUT_W         = 48;
    localparam int DIVISOR_W     = 16;

    localparam logic signed [VALUE_W-1:0] OUT_MAX =
        {{(VALUE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] OUT_MIN =
        {{(VALUE_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef enum logic [4:0] {
        F_RAW_A      = 5'd0,
        F_A_OFF      = 5'd1,
        F_PCT_255    = 5'd2,
        F_PCT_128    = 5'd3,
        F_SPCT       = 5'd4,
        F_A_MUL      = 5'd5,
        F_A_200      = 5'd6,
        F_A_HALF_OFF = 5'd7,
        F_A_M64      = 5'd8,
        F_A_40       = 5'd9,
        F_AB         = 5'd10,
        F_AB_DIV     = 5'd11,
        F_SAB_DIV    = 5'd12,
        F_AB_MUL     = 5'd13,
        F_AB_DIV_OFF = 5'd14,
        F_AB_32768   = 5'd15,
        F_AB_4       = 5'd16,
        F_NONNUM     = 5'd17
    } t_formula;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] base;
        logic                      use_div;
        logic                      neg;
        logic                      sub_off;
        logic                      unknown;
        logic signed [31:0]        off;
    } t_side;

endpackage
`default_nettype wire

// ===== hdl/obd_pid_value_decoder_unit.sv =====
// Top level of the OBD PID value decoder: decode, pipelined divide, offset, saturate.
// Depends on obd_pkg and obd_div.
// Registers from start to o_valid, in order: input register, decode/multiply register,
// one divider stage per quotient bit, output register.
// Throughput: one beat per cycle; busy stays low. Reset clears all valid bits.
`default_nettype none
module obd_pid_value_decoder_unit #(
    parameter int FRACTION_BITS = obd_pkg::FRACTION_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [4:0]                   i_formula_code,
    input  wire logic signed [31:0]           i_offset_value,
    input  wire logic [31:0]                  i_scale_factor,
    input  wire logic [15:0]                  i_divisor_value,
    input  wire logic [7:0]                   i_byte_a,
    input  wire logic [7:0]                   i_byte_b,
    input  wire logic [3:0]                   i_data_length,
    output logic                              o_valid,
    output logic signed [obd_pkg::OUT_W-1:0]  o_scaled_value,
    output logic                              o_unknown_formula
);
    localparam int F  = FRACTION_BITS;
    localparam int VW = obd_pkg::VALUE_W;
    localparam int DW = 16 + F;

    // stage 0: input capture
    logic               r_v0;
    logic [4:0]         r_code;
    logic signed [31:0] r_off;
    logic [31:0]        r_mul;
    logic [15:0]        r_div;
    logic [7:0]         r_a;
    logic [7:0]         r_b;
    logic               r_len0;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_code <= i_formula_code;
        r_off  <= i_offset_value;
        r_mul  <= i_scale_factor;
        r_div  <= i_divisor_value;
        r_a    <= i_byte_a;
        r_b    <= (i_data_length > 4'd1) ? i_byte_b : 8'h00;
        r_len0 <= (i_data_length == 4'd0);
    end

    // stage 1: decode and multiply
    logic [15:0]           w_ab;
    logic signed [VW-1:0]  w_a_fx;
    logic signed [VW-1:0]  w_ab_fx;
    logic signed [VW-1:0]  w_sab_fx;
    logic signed [15:0]    w_t4;
    logic signed [15:0]    w_m4;
    logic [15:0]           w_word;
    logic [47:0]           w_prod;
    logic [DW-1:0]         w_mag;
    logic [15:0]           w_dsr;
    logic                  w_sneg;
    logic [15:0]           w_sabs;
    obd_pkg::t_side        w_side;

    assign w_ab     = {r_a, r_b};
    assign w_a_fx   = $signed(VW'(r_a)) <<< F;
    assign w_ab_fx  = $signed(VW'(w_ab)) <<< F;
    assign w_sab_fx = VW'($signed(w_ab)) <<< F;
    assign w_t4     = $signed({8'h00, r_a}) - 16'sd128;
    assign w_m4     = w_t4 * 16'sd100;
    assign w_word   = (r_code == obd_pkg::F_A_MUL) ? {8'h00, r_a} : w_ab;
    assign w_prod   = 48'(w_word) * 48'(r_mul);
    assign w_sneg   = w_ab[15];
    assign w_sabs   = w_sneg ? (16'd0 - w_ab) : w_ab;

    always_comb begin
        w_mag          = '0;
        w_dsr          = 16'd1;
        w_side         = '0;
        w_side.valid   = r_v0;
        w_side.off     = r_off;
        if (!r_len0) begin
            unique case (r_code)
                obd_pkg::F_RAW_A: w_side.base = w_a_fx;
                obd_pkg::F_A_OFF: begin
                    w_side.base    = w_a_fx;
                    w_side.sub_off = 1'b1;
                end
                obd_pkg::F_PCT_255: begin
                    w_side.use_div = 1'b1;
                    w_mag          = DW'(16'(r_a) * 16'd100) << F;
                    w_dsr          = 16'd255;
                end
                obd_pkg::F_PCT_128: w_side.base = $signed(VW'(16'(r_a) * 16'd100)) <<< (F - 7);
                obd_pkg::F_SPCT: begin
                    w_side.use_div = 1'b1;
                    w_side.neg     = w_m4[15];
                    w_mag          = DW'(w_m4[15] ? 16'(-w_m4) : 16'(w_m4)) << F;
                    w_dsr          = 16'd128;
                end
                obd_pkg::F_A_MUL: w_side.base = $signed(VW'(w_prod));
                obd_pkg::F_A_200: begin
                    w_side.use_div = 1'b1;
                    w_mag          = DW'(r_a) << F;
                    w_dsr          = 16'd200;
                end
                obd_pkg::F_A_HALF_OFF: begin
                    w_side.base    = w_a_fx >>> 1;
                    w_side.sub_off = 1'b1;
                end
                obd_pkg::F_A_M64: w_side.base = ($signed(VW'(r_a)) - VW'(64)) <<< F;
                obd_pkg::F_A_40:  w_side.base = $signed(VW'(16'(r_a) * 16'd40)) <<< F;
                obd_pkg::F_AB, obd_pkg::F_NONNUM: w_side.base = w_ab_fx;
                obd_pkg::F_AB_DIV, obd_pkg::F_AB_DIV_OFF: begin
                    w_side.base    = w_ab_fx;
                    w_side.use_div = (r_div != 16'd0);
                    w_side.sub_off = (r_code == obd_pkg::F_AB_DIV_OFF);
                    w_mag          = DW'(w_ab) << F;
                    w_dsr          = r_div;
                end
                obd_pkg::F_SAB_DIV: begin
                    w_side.base    = w_sab_fx;
                    w_side.use_div = (r_div != 16'd0);
                    w_side.neg     = w_sneg;
                    w_mag          = DW'(w_sabs) << F;
                    w_dsr          = r_div;
                end
                obd_pkg::F_AB_MUL:   w_side.base = $signed(VW'(w_prod));
                obd_pkg::F_AB_32768: w_side.base = w_ab_fx >>> 15;
                obd_pkg::F_AB_4:     w_side.base = w_ab_fx >>> 2;
                default: begin
                    w_side.base    = w_a_fx;
                    w_side.unknown = 1'b1;
                end
            endcase
        end
    end

    logic [DW-1:0]  r_mag;
    logic [15:0]    r_dsr;
    obd_pkg::t_side r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= w_side.valid;
        end
        r_s1.base    <= w_side.base;
        r_s1.use_div <= w_side.use_div;
        r_s1.neg     <= w_side.neg;
        r_s1.sub_off <= w_side.sub_off;
        r_s1.unknown <= w_side.unknown;
        r_s1.off     <= w_side.off;
        r_mag        <= w_mag;
        r_dsr        <= w_dsr;
    end

    // divider stages with matching sideband
    logic [DW-1:0] w_quot;

    obd_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_dividend (r_mag),
        .i_divisor  (r_dsr),
        .o_quotient (w_quot)
    );

    obd_pkg::t_side r_side [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_side
            obd_pkg::t_side w_in;
            if (k == 0) begin : g_first
                assign w_in = r_s1;
            end else begin : g_next
                assign w_in = r_side[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k].valid <= 1'b0;
                end else begin
                    r_side[k].valid <= w_in.valid;
                end
                r_side[k].base    <= w_in.base;
                r_side[k].use_div <= w_in.use_div;
                r_side[k].neg     <= w_in.neg;
                r_side[k].sub_off <= w_in.sub_off;
                r_side[k].unknown <= w_in.unknown;
                r_side[k].off     <= w_in.off;
            end
        end
    endgenerate

    // final: sign, offset, saturate
    obd_pkg::t_side        w_fin;
    logic signed [VW-1:0]  w_q;
    logic signed [VW-1:0]  w_v;
    logic signed [VW-1:0]  w_v2;
    logic signed [obd_pkg::OUT_W-1:0] n_value;

    assign w_fin = r_side[DW-1];
    assign w_q   = $signed(VW'(w_quot));
    assign w_v   = w_fin.use_div ? (w_fin.neg ? -w_q : w_q) : w_fin.base;
    assign w_v2  = w_fin.sub_off ? (w_v - VW'(w_fin.off)) : w_v;

    always_comb begin
        priority if (w_v2 > obd_pkg::OUT_MAX) begin
            n_value = obd_pkg::OUT_MAX[obd_pkg::OUT_W-1:0];
        end else if (w_v2 < obd_pkg::OUT_MIN) begin
            n_value = obd_pkg::OUT_MIN[obd_pkg::OUT_W-1:0];
        end else begin
            n_value = w_v2[obd_pkg::OUT_W-1:0];
        end
    end

    logic                              r_valid;
    logic signed [obd_pkg::OUT_W-1:0]  r_value;
    logic                              r_unknown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_fin.valid;
        end
        r_value   <= n_value;
        r_unknown <= w_fin.unknown;
    end

    assign o_valid           = r_valid;
    assign o_scaled_value    = r_value;
    assign o_unknown_formula = r_unknown;
endmodule
`default_nettype wire

// ===== hdl/obd_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on obd_pkg.
`default_nettype none
module obd_div #(
    parameter int DW = 16 + obd_pkg::FRACTION_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic [DW-1:0]                    i_dividend,
    input  wire logic [obd_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic      [DW-1:0]                    o_quotient
);
    localparam int BW = obd_pkg::DIVISOR_W;

    logic [BW-1:0] r_rem [DW];
    logic [DW-1:0] r_dvd [DW];
    logic [BW-1:0] r_dsr [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_stage
            logic [BW-1:0] w_rem;
            logic [DW-1:0] w_dvd;
            logic [BW-1:0] w_dsr;
            logic [BW:0]   w_t;
            logic [BW:0]   w_diff;
            logic          w_bit;
            if (k == 0) begin : g_first
                assign w_rem = '0;
                assign w_dvd = i_dividend;
                assign w_dsr = i_divisor;
            end else begin : g_next
                assign w_rem = r_rem[k-1];
                assign w_dvd = r_dvd[k-1];
                assign w_dsr = r_dsr[k-1];
            end
            assign w_t    = {w_rem, w_dvd[DW-1]};
            assign w_diff = w_t - {1'b0, w_dsr};
            assign w_bit  = (w_t >= {1'b0, w_dsr});
            always_ff @(posedge i_clk) begin
                r_rem[k] <= w_bit ? w_diff[BW-1:0] : w_t[BW-1:0];
                r_dvd[k] <= {w_dvd[DW-2:0], w_bit};
                r_dsr[k] <= w_dsr;
            end
        end
    endgenerate

    assign o_quotient = r_dvd[DW-1];
endmodule
`default_nettype wire
